// ===== sv/gauss_jordan_matrix_inverse_assert.svh =====
// Assertion macros shared by the matrix inverse controller and datapath.
`ifndef GAUSS_JORDAN_MATRIX_INVERSE_ASSERT_SVH
`define GAUSS_JORDAN_MATRIX_INVERSE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GJMI_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GJMI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/gjmi_pkg.sv =====
// Shared types and constants of the Gauss-Jordan matrix inverse.
`timescale 1ns / 1ps

package gjmi_pkg;

    // Row and column index width (columns of the augmented store reach 15)
    localparam int IDX_W  = 4;
    localparam int DATA_W = 32;

    // Result status codes
    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_ZERO_PIVOT = 2'd1;
    localparam logic [1:0] STAT_SAT        = 2'd2;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_IDENT,
        ST_PIV_RD,
        ST_PIV_CHK,
        ST_RAT_RD,
        ST_RAT_DIV,
        ST_RAT_WAIT,
        ST_ROW,
        ST_DRAIN,
        ST_FPIV_RD,
        ST_FPIV_CHK,
        ST_FIN_RD,
        ST_FIN_DIV,
        ST_FIN_WAIT,
        ST_OUT_RD,
        ST_OUT_CAP,
        ST_OUT_HOLD
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic             ld_wr;
        logic             id_wr;
        logic             id_one;
        logic             fin_wr;
        logic [IDX_W-1:0] wr_row;
        logic [IDX_W-1:0] wr_col;
        logic [IDX_W-1:0] rd_row_a;
        logic [IDX_W-1:0] rd_row_b;
        logic [IDX_W-1:0] rd_col;
        logic             row_issue;
        logic             piv_ld;
        logic             div_start;
        logic             rat_ld;
        logic             set_err;
        logic             clr_flags;
        logic             out_ld;
        logic             out_last;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic piv_zero;
        logic div_done;
        logic pipe_idle;
    } sts_t;

endpackage

// ===== sv/gauss_jordan_matrix_inverse.sv =====
// Top level of the Gauss-Jordan fixed-point matrix inverse.
`timescale 1ns / 1ps

// Inverts an N x N signed fixed-point matrix (N from cfg_wdata, 1..MAX_DIM,
// reset 4; zero acts as 1). Elements arrive on the s_ channel row-major, one
// per transaction, one per cycle while loading. After the last element the
// block fills the identity, eliminates without pivoting and divides the
// right half by the pivots, then sends the N*N inverse elements row-major on
// the m_ channel with the status in m_tuser and m_tlast on the final element.
// Each row update streams 2N columns through a multiply and subtract
// pipeline, one per cycle; each ratio and each final quotient takes one pass
// of the radix-2 divider. Each result is read from the store's registered
// read port into the output register and then offered on the m_ channel.
// While the receiver stalls the result holds in the output register; no
// input is taken until the whole inverse has gone out. A zero pivot gives
// status 1 and zero data on every element; saturation gives status 2.
// Reset (or a size write) returns to loading with an empty count.

module gauss_jordan_matrix_inverse import gjmi_pkg::*; #(
    parameter int MAX_DIM   = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,     // dim_in_use
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // [31:0] element_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,       // [31:0] element_out
    output logic [1:0]  m_tuser,       // [1:0] status
    output logic        m_tlast
);

    cmd_t cmd;
    sts_t sts;
    logic signed [DATA_W-1:0] element_out;

    gjmi_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    gjmi_datapath #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .element_in  ($signed(s_tdata)),
        .element_out (element_out),
        .status      (m_tuser),
        .last        (m_tlast)
    );

    assign m_tdata = element_out;

endmodule

// ===== sv/gjmi_ram.sv =====
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps

module gjmi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== sv/gjmi_div.sv =====
// Iterative signed fixed-point divider: sat32(trunc(num * 2^FRAC_BITS / den)).
`timescale 1ns / 1ps

module gjmi_div import gjmi_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [DATA_W-1:0] num,
    input  logic signed [DATA_W-1:0] den,
    output logic                     busy,
    output logic                     done,
    output logic signed [DATA_W-1:0] quo,
    output logic                     sat
);

    localparam int NUM_W = DATA_W + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  dvd_reg;     // dividend shifts out, quotient shifts in
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] den_reg;
    logic              neg_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DATA_W-1:0] num_mag;
    logic [DATA_W-1:0] den_mag;
    logic [DATA_W:0]   rem_sh;
    logic              q_bit;
    logic [DATA_W:0]   rem_sub;

    assign num_mag = num[DATA_W-1] ? DATA_W'(-num) : DATA_W'(num);
    assign den_mag = den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);

    // One restoring step per cycle
    assign rem_sh  = {rem_reg, dvd_reg[NUM_W-1]};
    assign q_bit   = (rem_sh >= {1'b0, den_reg});
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= {num_mag, {FRAC_BITS{1'b0}}};
            rem_reg <= '0;
            den_reg <= den_mag;
            neg_reg <= num[DATA_W-1] ^ den[DATA_W-1];
        end else if (busy_reg) begin
            rem_reg <= q_bit ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
            dvd_reg <= {dvd_reg[NUM_W-2:0], q_bit};
        end
    end

    // Sign and saturation of the quotient magnitude
    localparam logic [NUM_W-1:0] MAG_NEG_LIM = NUM_W'(33'h0_8000_0000);
    localparam logic [NUM_W-1:0] MAG_POS_LIM = NUM_W'(33'h0_7FFF_FFFF);

    always_comb begin
        sat = 1'b0;
        if (neg_reg) begin
            if (dvd_reg > MAG_NEG_LIM) begin
                sat = 1'b1;
                quo = 32'sh8000_0000;
            end else begin
                quo = DATA_W'(-dvd_reg);
            end
        end else begin
            if (dvd_reg > MAG_POS_LIM) begin
                sat = 1'b1;
                quo = 32'sh7FFF_FFFF;
            end else begin
                quo = dvd_reg[DATA_W-1:0];
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

// ===== sv/gjmi_datapath.sv =====
// Datapath: augmented store, multiply-subtract pipeline, divider, flags, output register.
`timescale 1ns / 1ps

module gjmi_datapath import gjmi_pkg::*; #(
    parameter int MAX_DIM   = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cmd_t                     cmd,
    output sts_t                     sts,
    input  logic signed [DATA_W-1:0] element_in,
    output logic signed [DATA_W-1:0] element_out,
    output logic [1:0]               status,
    output logic                     last
);

    localparam int ROW_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int COL_W  = ROW_W + 1;
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int DEPTH  = 1 << ADDR_W;

    localparam logic signed [DATA_W-1:0] ONE_Q = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [64:0]       MAX65 = 65'sd2147483647;
    localparam logic signed [64:0]       MIN65 = -65'sd2147483648;

    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] cmd_wr_addr;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic              wr_en;
    logic [DATA_W-1:0] wr_data;
    logic [DATA_W-1:0] rd_a;
    logic [DATA_W-1:0] rd_b;
    logic signed [DATA_W-1:0] rd_a_s;

    logic signed [DATA_W-1:0] piv_reg;
    logic signed [DATA_W-1:0] ratio_reg;
    logic signed [63:0]       prod_reg;
    logic signed [DATA_W-1:0] aj_reg;
    logic                     v1_reg;
    logic                     v2_reg;
    logic [ADDR_W-1:0]        tag1_reg;
    logic [ADDR_W-1:0]        tag2_reg;
    logic                     sat_reg;
    logic                     err_reg;
    logic signed [DATA_W-1:0] out_data_reg;
    logic [1:0]               out_stat_reg;
    logic                     out_last_reg;

    logic signed [64:0]       diff;
    logic                     ovf_hi;
    logic                     ovf_lo;
    logic [DATA_W-1:0]        pipe_res;

    logic                     div_busy;
    logic                     div_done;
    logic signed [DATA_W-1:0] div_quo;
    logic                     div_sat;

    assign rd_a_s      = $signed(rd_a);
    assign cmd_wr_addr = {cmd.wr_row[ROW_W-1:0], cmd.wr_col[COL_W-1:0]};
    assign rd_addr_a   = {cmd.rd_row_a[ROW_W-1:0], cmd.rd_col[COL_W-1:0]};
    assign rd_addr_b   = {cmd.rd_row_b[ROW_W-1:0], cmd.rd_col[COL_W-1:0]};

    gjmi_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .we      (wr_en),
        .waddr   (wr_addr),
        .wdata   (wr_data),
        .raddr_a (rd_addr_a),
        .rdata_a (rd_a),
        .raddr_b (rd_addr_b),
        .rdata_b (rd_b)
    );

    gjmi_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (rd_a_s),
        .den     (piv_reg),
        .busy    (div_busy),
        .done    (div_done),
        .quo     (div_quo),
        .sat     (div_sat)
    );

    // Row update pipeline: read, multiply, subtract and saturate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.row_issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        tag1_reg <= cmd_wr_addr;
        if (v1_reg) begin
            prod_reg <= ratio_reg * rd_a_s;
            aj_reg   <= $signed(rd_b);
            tag2_reg <= tag1_reg;
        end
        if (cmd.piv_ld) begin
            piv_reg <= rd_a_s;
        end
        if (cmd.rat_ld) begin
            ratio_reg <= div_quo;
        end
    end

    // floor(ratio * a / 2^F) is an arithmetic shift of the full product
    assign diff   = 65'(aj_reg) - 65'(prod_reg >>> FRAC_BITS);
    assign ovf_hi = (diff > MAX65);
    assign ovf_lo = (diff < MIN65);

    always_comb begin
        if (ovf_hi) begin
            pipe_res = 32'h7FFF_FFFF;
        end else if (ovf_lo) begin
            pipe_res = 32'h8000_0000;
        end else begin
            pipe_res = diff[DATA_W-1:0];
        end
    end

    // Store write port select
    always_comb begin
        wr_en   = 1'b1;
        wr_addr = cmd_wr_addr;
        wr_data = '0;
        if (v2_reg) begin
            wr_addr = tag2_reg;
            wr_data = pipe_res;
        end else if (cmd.ld_wr) begin
            wr_data = element_in;
        end else if (cmd.id_wr) begin
            wr_data = cmd.id_one ? ONE_Q : '0;
        end else if (cmd.fin_wr) begin
            wr_data = div_quo;
        end else begin
            wr_en = 1'b0;
        end
    end

    // Error and saturation flags of the current inversion
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clr_flags) begin
            sat_reg <= 1'b0;
            err_reg <= 1'b0;
        end else begin
            if ((v2_reg && (ovf_hi || ovf_lo)) || ((cmd.rat_ld || cmd.fin_wr) && div_sat)) begin
                sat_reg <= 1'b1;
            end
            if (cmd.set_err) begin
                err_reg <= 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (cmd.out_ld) begin
            out_data_reg <= err_reg ? '0 : rd_a_s;
            out_stat_reg <= err_reg ? STAT_ZERO_PIVOT : (sat_reg ? STAT_SAT : STAT_OK);
            out_last_reg <= cmd.out_last;
        end
    end

    assign element_out   = out_data_reg;
    assign status        = out_stat_reg;
    assign last          = out_last_reg;

    assign sts.piv_zero  = (rd_a == '0);
    assign sts.div_done  = div_done;
    assign sts.pipe_idle = !v1_reg && !v2_reg;

`include "gauss_jordan_matrix_inverse_assert.svh"

    `GJMI_ASSERT_SAME(a_wr_conflict, v2_reg, !(cmd.ld_wr || cmd.id_wr || cmd.fin_wr), "store write conflict")
    `GJMI_ASSERT_NEXT(a_div_no_early_done, cmd.div_start, !div_done, "divider done too early")
    `GJMI_ASSERT_SAME(a_row_div_idle, cmd.row_issue, !div_busy, "row update while divider runs")

endmodule

// ===== sv/gjmi_ctrl.sv =====
// Controller: load, identity fill, elimination, final divide and output sequencing.
`timescale 1ns / 1ps

module gjmi_ctrl import gjmi_pkg::*; #(
    parameter int MAX_DIM = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [3:0]       cfg_wdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output cmd_t             cmd,
    input  sts_t             sts
);

    state_t           state_reg, state_next;
    logic [3:0]       dim_reg;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;

    logic [IDX_W-1:0] n_eff;
    logic [IDX_W-1:0] nm1;
    logic [IDX_W-1:0] n2m1;
    logic [IDX_W-1:0] col_hi;
    logic [IDX_W-1:0] j_first;
    logic [IDX_W-1:0] j_after;
    logic             k_end;
    logic             i_end;

    // Effective size: zero acts as one, large values clamp
    always_comb begin
        if (dim_reg == 4'd0) begin
            n_eff = IDX_W'(1);
        end else if (dim_reg > IDX_W'(MAX_DIM)) begin
            n_eff = IDX_W'(MAX_DIM);
        end else begin
            n_eff = dim_reg;
        end
    end

    assign nm1     = n_eff - 1'b1;
    assign n2m1    = IDX_W'({n_eff, 1'b0} - 1'b1);
    assign col_hi  = n_eff + k_reg;
    assign k_end   = (k_reg == nm1);
    assign i_end   = (i_reg == nm1);
    assign j_first = (i_reg == '0) ? IDX_W'(1) : '0;
    assign j_after = ((j_reg + 1'b1) == i_reg) ? (j_reg + IDX_W'(2)) : (j_reg + 1'b1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            dim_reg   <= 4'd4;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            if (cfg_we) begin
                dim_reg <= cfg_wdata;
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        cmd          = '0;
        cmd.rd_row_a = i_reg;
        cmd.rd_row_b = j_reg;
        cmd.rd_col   = k_reg;
        cmd.wr_row   = i_reg;
        cmd.wr_col   = k_reg;
        s_tready     = 1'b0;
        m_tvalid     = 1'b0;

        case (state_reg)
            // Row-major element load into the left half
            ST_LOAD: begin
                s_tready = !cfg_we;
                if (s_tvalid && !cfg_we) begin
                    cmd.ld_wr = 1'b1;
                    if (k_end) begin
                        k_next = '0;
                        if (i_end) begin
                            i_next     = '0;
                            state_next = ST_IDENT;
                        end else begin
                            i_next = i_reg + 1'b1;
                        end
                    end else begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            // Identity into the right half
            ST_IDENT: begin
                cmd.id_wr  = 1'b1;
                cmd.id_one = (i_reg == k_reg);
                cmd.wr_col = col_hi;
                if (k_end) begin
                    k_next = '0;
                    if (i_end) begin
                        i_next     = '0;
                        state_next = ST_PIV_RD;
                    end else begin
                        i_next = i_reg + 1'b1;
                    end
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_PIV_RD: begin
                cmd.rd_col = i_reg;
                state_next = ST_PIV_CHK;
            end
            ST_PIV_CHK: begin
                cmd.piv_ld = 1'b1;
                if (sts.piv_zero) begin
                    cmd.set_err = 1'b1;
                    i_next      = '0;
                    k_next      = '0;
                    state_next  = ST_OUT_RD;
                end else if (j_first > nm1) begin
                    if (i_end) begin
                        i_next     = '0;
                        state_next = ST_FPIV_RD;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_PIV_RD;
                    end
                end else begin
                    j_next     = j_first;
                    state_next = ST_RAT_RD;
                end
            end
            ST_RAT_RD: begin
                cmd.rd_row_a = j_reg;
                cmd.rd_col   = i_reg;
                state_next   = ST_RAT_DIV;
            end
            ST_RAT_DIV: begin
                cmd.div_start = 1'b1;
                state_next    = ST_RAT_WAIT;
            end
            ST_RAT_WAIT: begin
                if (sts.div_done) begin
                    cmd.rat_ld = 1'b1;
                    k_next     = '0;
                    state_next = ST_ROW;
                end
            end
            // One column of row j per cycle into the update pipeline
            ST_ROW: begin
                cmd.row_issue = 1'b1;
                cmd.wr_row    = j_reg;
                if (k_reg == n2m1) begin
                    state_next = ST_DRAIN;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (sts.pipe_idle) begin
                    if (j_after > nm1) begin
                        if (i_end) begin
                            i_next     = '0;
                            state_next = ST_FPIV_RD;
                        end else begin
                            i_next     = i_reg + 1'b1;
                            state_next = ST_PIV_RD;
                        end
                    end else begin
                        j_next     = j_after;
                        state_next = ST_RAT_RD;
                    end
                end
            end
            // Final divide of the right half by each pivot
            ST_FPIV_RD: begin
                cmd.rd_col = i_reg;
                state_next = ST_FPIV_CHK;
            end
            ST_FPIV_CHK: begin
                cmd.piv_ld = 1'b1;
                k_next     = '0;
                if (sts.piv_zero) begin
                    cmd.set_err = 1'b1;
                    i_next      = '0;
                    state_next  = ST_OUT_RD;
                end else begin
                    state_next = ST_FIN_RD;
                end
            end
            ST_FIN_RD: begin
                cmd.rd_col = col_hi;
                state_next = ST_FIN_DIV;
            end
            ST_FIN_DIV: begin
                cmd.div_start = 1'b1;
                state_next    = ST_FIN_WAIT;
            end
            ST_FIN_WAIT: begin
                cmd.wr_col = col_hi;
                if (sts.div_done) begin
                    cmd.fin_wr = 1'b1;
                    if (k_end) begin
                        k_next = '0;
                        if (i_end) begin
                            i_next     = '0;
                            state_next = ST_OUT_RD;
                        end else begin
                            i_next     = i_reg + 1'b1;
                            state_next = ST_FPIV_RD;
                        end
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_FIN_RD;
                    end
                end
            end
            // Inverse out, row-major
            ST_OUT_RD: begin
                cmd.rd_col = col_hi;
                state_next = ST_OUT_CAP;
            end
            ST_OUT_CAP: begin
                cmd.out_ld   = 1'b1;
                cmd.out_last = i_end && k_end;
                state_next   = ST_OUT_HOLD;
            end
            ST_OUT_HOLD: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (i_end && k_end) begin
                        cmd.clr_flags = 1'b1;
                        i_next        = '0;
                        k_next        = '0;
                        state_next    = ST_LOAD;
                    end else if (k_end) begin
                        k_next     = '0;
                        i_next     = i_reg + 1'b1;
                        state_next = ST_OUT_RD;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase

        // A size write drops any partial matrix
        if (cfg_we) begin
            state_next    = ST_LOAD;
            i_next        = '0;
            j_next        = '0;
            k_next        = '0;
            cmd.clr_flags = 1'b1;
        end
    end

`include "gauss_jordan_matrix_inverse_assert.svh"

    `GJMI_ASSERT_SAME(a_no_in_during_out, m_tvalid, !s_tready, "input taken during output")
    `GJMI_ASSERT_NEXT(a_drain_hold, (state_reg == ST_DRAIN) && !sts.pipe_idle && !cfg_we, state_reg == ST_DRAIN, "left drain with pipeline busy")
    `GJMI_ASSERT_NEXT(a_out_valid, cmd.out_ld && !cfg_we, m_tvalid, "captured result not offered")

endmodule
